### rtl/lsrc_pkg.sv
// Shared types, constants and helpers for the line segment rectangle clipper.
package lsrc_pkg;

    localparam int CoordW     = 16;
    localparam int MaxPasses  = 4;
    localparam int ProdW      = 2 * (CoordW + 1);
    localparam int DenW       = CoordW;
    localparam int DivBits    = 4;
    localparam int DivStages  = (ProdW + DivBits - 1) / DivBits;
    localparam int QuoW       = DivStages * DivBits;
    localparam int SumW       = QuoW + 2;

    localparam logic [3:0] CodeInside = 4'd0;
    localparam logic [3:0] CodeLeft   = 4'd1;
    localparam logic [3:0] CodeRight  = 4'd2;
    localparam logic [3:0] CodeBottom = 4'd4;
    localparam logic [3:0] CodeTop    = 4'd8;

    localparam logic [1:0] RegLeft   = 2'd0;
    localparam logic [1:0] RegBottom = 2'd1;
    localparam logic [1:0] RegRight  = 2'd2;
    localparam logic [1:0] RegTop    = 2'd3;

    typedef logic signed [CoordW-1:0] coord_t;

    typedef struct packed {
        coord_t left;
        coord_t bottom;
        coord_t right;
        coord_t top;
    } win_t;

    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        logic   done;
        logic   acc;
    } seg_t;

    typedef struct packed {
        logic   move_end;
        logic   horiz;
        coord_t edge_val;
        coord_t base;
        logic   neg;
        logic   den_zero;
    } clip_t;

    function automatic logic [3:0] region_code(coord_t x, coord_t y, win_t w);
        logic [3:0] c;
        c = CodeInside;
        if (x < w.left) c = c | CodeLeft;
        else if (x > w.right) c = c | CodeRight;
        if (y < w.bottom) c = c | CodeBottom;
        else if (y > w.top) c = c | CodeTop;
        return c;
    endfunction

endpackage

### rtl/lsrc_pass.sv
// One clip pass: edge select, multiply, pipelined divide, crossing update.
module lsrc_pass (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  lsrc_pkg::win_t win,
    input  logic          in_valid,
    input  lsrc_pkg::seg_t in_seg,
    output logic          out_valid,
    output lsrc_pkg::seg_t out_seg
);
    import lsrc_pkg::*;

    // setup stage
    logic [3:0]          c0, c1, sel;
    logic signed [CoordW:0] dx, dy, span_c, reach_c, den_c;
    seg_t                seg_c;
    clip_t               clip_c;

    logic                s1_valid_reg;
    seg_t                s1_seg_reg;
    clip_t               s1_clip_reg;
    logic signed [CoordW:0] s1_span_reg, s1_reach_reg, s1_den_reg;

    logic                s2_valid_reg;
    seg_t                s2_seg_reg;
    clip_t               s2_clip_reg;
    logic signed [ProdW-1:0] s2_prod_reg;
    logic signed [CoordW:0]  s2_den_reg;

    logic [ProdW-1:0]    prod_mag;
    logic [CoordW:0]     den_mag;
    clip_t               dclip_c;

    logic                dv_reg   [DivStages+1];
    seg_t                dseg_reg [DivStages+1];
    clip_t               dclip_reg[DivStages+1];
    logic [QuoW-1:0]     dnum_reg [DivStages+1];
    logic [DenW-1:0]     drem_reg [DivStages+1];
    logic [DenW-1:0]     dden_reg [DivStages+1];

    logic                o_valid_reg;
    seg_t                o_seg_reg;

    logic signed [SumW-1:0] quo_s, sum_s;
    coord_t              cross_v, nx, ny;
    seg_t                fin_seg;

    function automatic logic [QuoW+DenW-1:0] div_step(logic [QuoW-1:0] num,
                                                      logic [DenW-1:0] rem,
                                                      logic [DenW-1:0] den);
        logic [DenW:0]   trial;
        logic [QuoW-1:0] n;
        logic [DenW-1:0] r;
        n = num;
        r = rem;
        for (int i = 0; i < DivBits; i++) begin
            trial = {r, n[QuoW-1]};
            n = {n[QuoW-2:0], 1'b0};
            if (trial >= {1'b0, den}) begin
                trial = trial - {1'b0, den};
                n[0] = 1'b1;
            end
            r = trial[DenW-1:0];
        end
        return {n, r};
    endfunction

    always_comb begin
        c0 = region_code(in_seg.x0, in_seg.y0, win);
        c1 = region_code(in_seg.x1, in_seg.y1, win);
        sel = (c0 != CodeInside) ? c0 : c1;
        dx = {in_seg.x1[CoordW-1], in_seg.x1} - {in_seg.x0[CoordW-1], in_seg.x0};
        dy = {in_seg.y1[CoordW-1], in_seg.y1} - {in_seg.y0[CoordW-1], in_seg.y0};
        seg_c = in_seg;
        clip_c.move_end = (c0 == CodeInside);
        clip_c.neg = 1'b0;
        clip_c.den_zero = 1'b0;
        if (!in_seg.done) begin
            if ((c0 | c1) == CodeInside) begin
                seg_c.done = 1'b1;
                seg_c.acc  = 1'b1;
            end else if ((c0 & c1) != CodeInside) begin
                seg_c.done = 1'b1;
                seg_c.acc  = 1'b0;
            end
        end
        if ((sel & CodeTop) != CodeInside) begin
            span_c = dx;
            reach_c = {win.top[CoordW-1], win.top} - {in_seg.y0[CoordW-1], in_seg.y0};
            den_c = dy;
            clip_c.horiz = 1'b1;
            clip_c.edge_val = win.top;
            clip_c.base = in_seg.x0;
        end else if ((sel & CodeBottom) != CodeInside) begin
            span_c = dx;
            reach_c = {win.bottom[CoordW-1], win.bottom} - {in_seg.y0[CoordW-1], in_seg.y0};
            den_c = dy;
            clip_c.horiz = 1'b1;
            clip_c.edge_val = win.bottom;
            clip_c.base = in_seg.x0;
        end else if ((sel & CodeRight) != CodeInside) begin
            span_c = dy;
            reach_c = {win.right[CoordW-1], win.right} - {in_seg.x0[CoordW-1], in_seg.x0};
            den_c = dx;
            clip_c.horiz = 1'b0;
            clip_c.edge_val = win.right;
            clip_c.base = in_seg.y0;
        end else begin
            span_c = dy;
            reach_c = {win.left[CoordW-1], win.left} - {in_seg.x0[CoordW-1], in_seg.x0};
            den_c = dx;
            clip_c.horiz = 1'b0;
            clip_c.edge_val = win.left;
            clip_c.base = in_seg.y0;
        end
    end

    always_comb begin
        prod_mag = s2_prod_reg[ProdW-1] ? ProdW'(-s2_prod_reg) : ProdW'(s2_prod_reg);
        den_mag  = s2_den_reg[CoordW] ? (CoordW+1)'(-s2_den_reg) : (CoordW+1)'(s2_den_reg);
        dclip_c          = s2_clip_reg;
        dclip_c.neg      = s2_prod_reg[ProdW-1] ^ s2_den_reg[CoordW];
        dclip_c.den_zero = (s2_den_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
            for (int k = 0; k <= DivStages; k++) dv_reg[k] <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            dv_reg[0]    <= s2_valid_reg;
            for (int k = 1; k <= DivStages; k++) dv_reg[k] <= dv_reg[k-1];
            o_valid_reg  <= dv_reg[DivStages];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_seg_reg   <= seg_c;
            s1_clip_reg  <= clip_c;
            s1_span_reg  <= span_c;
            s1_reach_reg <= reach_c;
            s1_den_reg   <= den_c;

            s2_seg_reg   <= s1_seg_reg;
            s2_clip_reg  <= s1_clip_reg;
            s2_prod_reg  <= ProdW'(s1_span_reg * s1_reach_reg);
            s2_den_reg   <= s1_den_reg;

            dseg_reg[0]          <= s2_seg_reg;
            dclip_reg[0]         <= dclip_c;
            dnum_reg[0]          <= QuoW'(prod_mag);
            drem_reg[0]          <= '0;
            dden_reg[0]          <= den_mag[DenW-1:0];

            for (int k = 1; k <= DivStages; k++) begin
                dseg_reg[k]  <= dseg_reg[k-1];
                dclip_reg[k] <= dclip_reg[k-1];
                dden_reg[k]  <= dden_reg[k-1];
                {dnum_reg[k], drem_reg[k]} <= div_step(dnum_reg[k-1], drem_reg[k-1],
                                                       dden_reg[k-1]);
            end

            o_seg_reg <= fin_seg;
        end
    end

    // apply sign, add base, saturate, move the chosen endpoint
    always_comb begin
        quo_s = $signed({2'b00, dnum_reg[DivStages]});
        if (dclip_reg[DivStages].neg) quo_s = -quo_s;
        if (dclip_reg[DivStages].den_zero) quo_s = '0;
        sum_s = SumW'(dclip_reg[DivStages].base) + quo_s;
        if (sum_s > SumW'(32767)) cross_v = 16'sh7fff;
        else if (sum_s < -SumW'(32768)) cross_v = 16'sh8000;
        else cross_v = sum_s[CoordW-1:0];
        nx = dclip_reg[DivStages].horiz ? cross_v : dclip_reg[DivStages].edge_val;
        ny = dclip_reg[DivStages].horiz ? dclip_reg[DivStages].edge_val : cross_v;
        fin_seg = dseg_reg[DivStages];
        if (!fin_seg.done) begin
            if (dclip_reg[DivStages].move_end) begin
                fin_seg.x1 = nx;
                fin_seg.y1 = ny;
            end else begin
                fin_seg.x0 = nx;
                fin_seg.y0 = ny;
            end
        end
    end

    assign out_valid = o_valid_reg;
    assign out_seg   = o_seg_reg;

endmodule

### rtl/line_segment_rect_clipper_core.sv
// Top level of the line segment rectangle clipper: ports, window registers, passes.
//
// channel  | ports            | item
// ---------+------------------+--------------------------------------------
// input    | s_tvalid/tready  | tdata: start_x, start_y, end_x, end_y
// result   | m_tvalid/tready  | tdata: clipped coords; tuser: accepted
// config   | APB psel/penable | window_left, bottom, right, top at 0,4,8,12
//
// One segment enters per cycle unless the pipeline stalls. The path from an accepted input
// item to m_tvalid runs through the input register, the four clip passes, each holding a
// multiplier and a pipelined divider that resolves four quotient bits per stage, and the
// output register.
// Reset (synchronous, active low) empties the pipeline and loads the default window.
// When the result is held, the whole pipeline stalls and s_tready drops.
module line_segment_rect_clipper_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // start_x, start_y, end_x, end_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
    output logic        m_tuser,   // accepted
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lsrc_pkg::*;

    win_t   win_reg;
    logic   adv;
    logic   in_valid_reg;
    seg_t   in_seg_reg;
    logic   pv   [MaxPasses+1];
    seg_t   pseg [MaxPasses+1];
    logic   out_valid_reg;
    logic   out_acc_reg;
    logic [63:0] out_data_reg;
    logic [3:0]  fc0, fc1;
    logic        fin_acc;
    seg_t        last;
    coord_t      rd_val;

    assign pready = 1'b1;
    assign adv = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg.left   <= 16'sd0;
            win_reg.bottom <= 16'sd0;
            win_reg.right  <= 16'sh7fff;
            win_reg.top    <= 16'sh7fff;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                RegLeft:   win_reg.left   <= pwdata[CoordW-1:0];
                RegBottom: win_reg.bottom <= pwdata[CoordW-1:0];
                RegRight:  win_reg.right  <= pwdata[CoordW-1:0];
                RegTop:    win_reg.top    <= pwdata[CoordW-1:0];
                default:   win_reg.left   <= win_reg.left;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            RegLeft:   rd_val = win_reg.left;
            RegBottom: rd_val = win_reg.bottom;
            RegRight:  rd_val = win_reg.right;
            RegTop:    rd_val = win_reg.top;
            default:   rd_val = '0;
        endcase
        prdata = {{(32-CoordW){rd_val[CoordW-1]}}, rd_val};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_seg_reg.x0   <= s_tdata[15:0];
            in_seg_reg.y0   <= s_tdata[31:16];
            in_seg_reg.x1   <= s_tdata[47:32];
            in_seg_reg.y1   <= s_tdata[63:48];
            in_seg_reg.done <= 1'b0;
            in_seg_reg.acc  <= 1'b0;
        end
    end

    assign pv[0]   = in_valid_reg;
    assign pseg[0] = in_seg_reg;

    for (genvar p = 0; p < MaxPasses; p++) begin : g_pass
        lsrc_pass u_pass (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .win       (win_reg),
            .in_valid  (pv[p]),
            .in_seg    (pseg[p]),
            .out_valid (pv[p+1]),
            .out_seg   (pseg[p+1])
        );
    end

    // final check after the last pass; anything still outside is rejected with zero coordinates
    always_comb begin
        last = pseg[MaxPasses];
        fc0 = region_code(last.x0, last.y0, win_reg);
        fc1 = region_code(last.x1, last.y1, win_reg);
        fin_acc = last.done ? last.acc : ((fc0 | fc1) == CodeInside);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= pv[MaxPasses];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_acc_reg  <= fin_acc;
            out_data_reg <= fin_acc ? {last.y1, last.x1, last.y0, last.x0} : 64'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_acc_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 64'd0)
        else $error("rejected segment carries nonzero coordinates");
    a_stall_holds_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("pipeline stalled without a blocked result");
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(pv[MaxPasses]) && $stable(in_valid_reg))
        else $error("pipeline moved during a stall");
    a_accept_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && pv[MaxPasses] && !last.done |=> m_tuser == $past((fc0 | fc1) == CodeInside))
        else $error("final accept does not follow region codes");
`endif

endmodule

### tb/tb_line_segment_rect_clipper_core.sv
// Self-checking testbench for the line segment rectangle clipper core.
module tb_line_segment_rect_clipper_core;
    import lsrc_pkg::*;

    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
    } segment_t;

    typedef struct packed {
        logic   acc;
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
    } clip_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // start_x, start_y, end_x, end_y
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
    logic        m_tuser;   // accepted
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    segment_t     pending_segs[$];
    clip_result_t expected_clips[$];
    win_t         win_model;
    int           errors;
    int           burst_left;
    int           gap_left;
    int           stall_phase;
    bit           hold_sender;
    logic         s_tready_q;

    line_segment_rect_clipper_core u_dut (.*);

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [3:0] outcode(int x, int y, win_t w);
        logic [3:0] c;
        c = CodeInside;
        if (x < int'(w.left)) c |= CodeLeft;
        else if (x > int'(w.right)) c |= CodeRight;
        if (y < int'(w.bottom)) c |= CodeBottom;
        else if (y > int'(w.top)) c |= CodeTop;
        return c;
    endfunction

    function automatic int edge_cross(int base, int span, int reach, int den);
        longint prod;
        longint q;
        longint s;
        prod = longint'(span) * longint'(reach);
        q = (den != 0) ? prod / longint'(den) : 0;
        s = longint'(base) + q;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return int'(s);
    endfunction

    function automatic clip_result_t clip_segment(segment_t sg, win_t w);
        clip_result_t r;
        int x0, y0, x1, y1, nx, ny;
        logic [3:0] c0, c1, sel;
        bit acc;
        x0 = int'(sg.x0); y0 = int'(sg.y0); x1 = int'(sg.x1); y1 = int'(sg.y1);
        c0 = outcode(x0, y0, w);
        c1 = outcode(x1, y1, w);
        acc = 0;
        for (int p = 0; p <= MaxPasses; p++) begin
            if ((c0 | c1) == 0) begin
                acc = 1;
                break;
            end
            if ((c0 & c1) != 0) break;
            if (p == MaxPasses) break;
            sel = (c0 != 0) ? c0 : c1;
            if (sel & CodeTop) begin
                nx = edge_cross(x0, x1 - x0, int'(w.top) - y0, y1 - y0);
                ny = int'(w.top);
            end else if (sel & CodeBottom) begin
                nx = edge_cross(x0, x1 - x0, int'(w.bottom) - y0, y1 - y0);
                ny = int'(w.bottom);
            end else if (sel & CodeRight) begin
                ny = edge_cross(y0, y1 - y0, int'(w.right) - x0, x1 - x0);
                nx = int'(w.right);
            end else begin
                ny = edge_cross(y0, y1 - y0, int'(w.left) - x0, x1 - x0);
                nx = int'(w.left);
            end
            if (c0 != 0) begin
                x0 = nx; y0 = ny; c0 = outcode(x0, y0, w);
            end else begin
                x1 = nx; y1 = ny; c1 = outcode(x1, y1, w);
            end
        end
        r.acc = acc;
        r.x0 = acc ? coord_t'(x0) : '0;
        r.y0 = acc ? coord_t'(y0) : '0;
        r.x1 = acc ? coord_t'(x1) : '0;
        r.y1 = acc ? coord_t'(y1) : '0;
        return r;
    endfunction

    // Sender: bursts and gaps; accepted items get their expected clip result.
    always @(negedge aclk) begin
        if (aresetn && s_tvalid && s_tready_q) begin
            expected_clips.push_back(clip_segment(pending_segs.pop_front(), win_model));
        end
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready_q) begin
            s_tvalid <= 1'b1;
        end else if (hold_sender) begin
            s_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            s_tvalid <= 1'b0;
        end else if (pending_segs.size() > 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                if ($urandom_range(0, 3) != 0) gap_left = $urandom_range(0, 6);
            end
            burst_left = burst_left - 1;
            s_tvalid <= 1'b1;
            s_tdata  <= {pending_segs[0].y1, pending_segs[0].x1,
                         pending_segs[0].y0, pending_segs[0].x0};
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Sample the input handshake at the rising edge.
    always @(posedge aclk) s_tready_q <= s_tvalid & s_tready;

    // Receiver stalls on a repeating pattern with random bits.
    always @(negedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (!aresetn) m_tready <= 1'b0;
        else if (stall_phase[8]) m_tready <= 1'b1;
        else m_tready <= (stall_phase[2:0] != 3'd5) && ($urandom_range(0, 3) != 0);
    end

    always @(posedge aclk) begin
        clip_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_clips.size() == 0) begin
                $error("result with no expected clip");
                errors++;
            end else begin
                want = expected_clips.pop_front();
                if (m_tuser !== want.acc) begin
                    $error("accepted exp %0d got %0d", want.acc, m_tuser);
                    errors++;
                end
                if (m_tdata[15:0] !== want.x0) begin
                    $error("clipped_start_x exp %0d got %0d", want.x0, $signed(m_tdata[15:0]));
                    errors++;
                end
                if (m_tdata[31:16] !== want.y0) begin
                    $error("clipped_start_y exp %0d got %0d", want.y0, $signed(m_tdata[31:16]));
                    errors++;
                end
                if (m_tdata[47:32] !== want.x1) begin
                    $error("clipped_end_x exp %0d got %0d", want.x1, $signed(m_tdata[47:32]));
                    errors++;
                end
                if (m_tdata[63:48] !== want.y1) begin
                    $error("clipped_end_y exp %0d got %0d", want.y1, $signed(m_tdata[63:48]));
                    errors++;
                end
            end
        end
    end

    task automatic write_window(logic [1:0] idx, coord_t value);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= {{16{value[15]}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            RegLeft:   win_model.left   = value;
            RegBottom: win_model.bottom = value;
            RegRight:  win_model.right  = value;
            default:   win_model.top    = value;
        endcase
    endtask

    task automatic drain_all();
        while (pending_segs.size() != 0 || expected_clips.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic coord_t pick_coord(win_t w, bit is_x);
        int low_edge, high_edge;
        low_edge = is_x ? int'(w.left) : int'(w.bottom);
        high_edge = is_x ? int'(w.right) : int'(w.top);
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2: return coord_t'(low_edge + $signed($urandom_range(0, 8)) - 4);
            3: return coord_t'(high_edge + $signed($urandom_range(0, 8)) - 4);
            default: return coord_t'(low_edge + (high_edge - low_edge) / 2
                                      + $signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic add_seg(int x0, int y0, int x1, int y1);
        segment_t sg;
        sg.x0 = coord_t'(x0); sg.y0 = coord_t'(y0);
        sg.x1 = coord_t'(x1); sg.y1 = coord_t'(y1);
        pending_segs.push_back(sg);
    endtask

    initial begin
        win_t w;
        errors = 0; burst_left = 0; gap_left = 0; stall_phase = 0; hold_sender = 0;
        s_tvalid = 0; s_tdata = '0; m_tready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        win_model = '{left: 0, bottom: 0, right: 32767, top: 32767};
        aresetn = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn = 1;

        // Default window, then a small one: inside, outside, crossing, extremes.
        add_seg(-32768, -32768, 32767, 32767);
        add_seg(100, 100, 200, 200);
        drain_all();
        write_window(RegLeft, -160); write_window(RegBottom, -160);
        write_window(RegRight, 160); write_window(RegTop, 160);
        add_seg(0, 0, 10, 10);               // trivially inside
        add_seg(-500, -500, -400, -300);     // shared outcode bit
        add_seg(-500, 0, 500, 0);            // left and right crossing
        add_seg(0, -500, 0, 500);            // bottom and top crossing
        add_seg(-400, -300, 300, 400);       // corner region both ends
        add_seg(-300, 200, 200, -300);       // clips through several passes
        add_seg(-32768, -32768, 32767, 32767);
        add_seg(32767, -32768, -32768, 32767);
        add_seg(-161, 200, 200, -161);       // corner regions both ends, crosses the window
        add_seg(-160, -160, 160, 160);       // exactly on edges
        add_seg(-170, 0, 0, 170);
        add_seg(-32768, 0, -32768, 32767);
        drain_all();
        // Inverted window, then the extremes.
        write_window(RegLeft, 200); write_window(RegRight, -200);
        add_seg(0, 0, 100, 100);
        add_seg(-300, 0, 300, 50);
        drain_all();
        write_window(RegLeft, -32768); write_window(RegBottom, -32768);
        write_window(RegRight, 32767); write_window(RegTop, 32767);
        add_seg(-32768, 32767, 32767, -32768);
        drain_all();

        for (int ph = 0; ph < 6; ph++) begin
            w.left   = coord_t'($urandom_range(0, 8000)) - 16'sd8000;
            w.bottom = coord_t'($urandom_range(0, 8000)) - 16'sd8000;
            w.right  = w.left + coord_t'($urandom_range(0, 16000));
            w.top    = w.bottom + coord_t'($urandom_range(0, 16000));
            if (ph == 5) begin
                w.left = 16'sh7fff; w.right = 16'sh8000;  // fully inverted extreme
            end
            write_window(RegLeft, w.left); write_window(RegBottom, w.bottom);
            write_window(RegRight, w.right); write_window(RegTop, w.top);
            for (int i = 0; i < 100; i++)
                add_seg(pick_coord(win_model, 1), pick_coord(win_model, 0),
                        pick_coord(win_model, 1), pick_coord(win_model, 0));
            if (ph == 2) begin
                // Hold off until the pipeline is empty.
                while (pending_segs.size() > 50) @(posedge aclk);
                hold_sender = 1;
                while (expected_clips.size() != 0 || s_tvalid) @(posedge aclk);
                hold_sender = 0;
            end
            drain_all();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
